[rtl/core/scsf_pkg.sv]
package scsf_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam int PIX_W    = 24;
    localparam int EN_W     = 19;
    localparam int FIELD_W  = 9;
    localparam int CFG_DW   = 10;
    localparam int CFG_IW   = 2;
    localparam int SQ_STEPS = 10;
    localparam int SQ_CNT_W = 4;

    localparam logic [CFG_IW-1:0] REG_DIRECTION = 2'd0;
    localparam logic [CFG_IW-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IW-1:0] REG_HEIGHT    = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef struct packed {
        logic       command;
        logic [8:0] pixel_row;
        logic [8:0] pixel_col;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_in_item;

    typedef struct packed {
        logic [8:0] seam_line;
        logic [8:0] seam_position;
        logic       last_entry;
    } t_out_item;

    // read address select
    typedef enum logic [2:0] {
        RS_PL, RS_PR, RS_PU, RS_PD, RS_EL, RS_EM, RS_ER, RS_EO
    } t_rsel;

    typedef enum logic [2:0] {
        CTR_HOLD, CTR_ENERGY, CTR_DP, CTR_MS, CTR_SEAM, CTR_NEXT
    } t_ctr;

    typedef struct packed {
        logic       pix_we;
        logic       pix_re;
        logic       en_re;
        logic       en_we;
        logic       en_wsel;   // 0 raw energy, 1 accumulated sum
        t_rsel      rsel;
        logic       cap_en;
        logic [1:0] cap_idx;
        logic       cap_pix;
        logic       dx;
        logic       sq_start;
        logic       sq_step;
        t_ctr       ctr_op;
        logic       line_mode;
        logic       best_upd;
        logic       seam_min;
        logic       bt_decide;
        logic       out_load;
        logic       seam_clr;
    } t_cmd;

    typedef struct packed {
        logic sq_busy;
        logic last_a;
        logic last_b;
        logic seam_valid;
        logic out_block;
    } t_stat;

    function automatic logic [17:0] colour_dist(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
        logic [17:0] sum;
        logic [7:0]  d;
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            d = (a[k*8 +: 8] > b[k*8 +: 8]) ? a[k*8 +: 8] - b[k*8 +: 8]
                                            : b[k*8 +: 8] - a[k*8 +: 8];
            sum = sum + (18'(d) * 18'(d));
        end
        return sum;
    endfunction

endpackage

[rtl/core/scsf_ram.sv]
module scsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[rtl/core/scsf_ctrl.sv]
module scsf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_fetch,
    input  scsf_pkg::t_stat i_stat,
    output scsf_pkg::t_cmd  o_cmd,
    output logic            o_in_stall
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_E0, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7,
        S_D0, S_D1, S_D2, S_D3, S_D4, S_D5,
        S_M0, S_M1, S_M2,
        S_B0, S_B1, S_B2, S_B3, S_B4, S_B5,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rsel   = scsf_pkg::RS_PL;
        o_cmd.ctr_op = scsf_pkg::CTR_HOLD;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_fetch == scsf_pkg::CMD_WRITE) begin
                        o_cmd.pix_we   = 1'b1;
                        o_cmd.seam_clr = 1'b1;
                    end else if (i_stat.seam_valid) begin
                        n_state = S_B0;
                    end else begin
                        o_cmd.ctr_op = scsf_pkg::CTR_ENERGY;
                        n_state      = S_E0;
                    end
                end
            end
            S_E0: begin
                o_cmd.pix_re = 1'b1;
                o_cmd.rsel   = scsf_pkg::RS_PL;
                n_state      = S_E1;
            end
            S_E1: begin
                o_cmd.pix_re  = 1'b1;
                o_cmd.rsel    = scsf_pkg::RS_PR;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_pix = 1'b1;
                o_cmd.cap_idx = 2'd0;
                n_state       = S_E2;
            end
            S_E2: begin
                o_cmd.pix_re  = 1'b1;
                o_cmd.rsel    = scsf_pkg::RS_PU;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_pix = 1'b1;
                o_cmd.cap_idx = 2'd1;
                n_state       = S_E3;
            end
            S_E3: begin
                o_cmd.pix_re  = 1'b1;
                o_cmd.rsel    = scsf_pkg::RS_PD;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_pix = 1'b1;
                o_cmd.cap_idx = 2'd2;
                o_cmd.dx      = 1'b1;
                n_state       = S_E4;
            end
            S_E4: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_pix = 1'b1;
                o_cmd.cap_idx = 2'd3;
                n_state       = S_E5;
            end
            S_E5: begin
                o_cmd.sq_start = 1'b1;
                n_state        = S_E6;
            end
            S_E6: begin
                if (i_stat.sq_busy) begin
                    o_cmd.sq_step = 1'b1;
                end else begin
                    n_state = S_E7;
                end
            end
            S_E7: begin
                o_cmd.en_we = 1'b1;
                if (i_stat.last_a && i_stat.last_b) begin
                    o_cmd.ctr_op = scsf_pkg::CTR_DP;
                    n_state      = S_D0;
                end else begin
                    o_cmd.ctr_op = scsf_pkg::CTR_NEXT;
                    n_state      = S_E0;
                end
            end
            S_D0: begin
                o_cmd.line_mode = 1'b1;
                o_cmd.en_re     = 1'b1;
                o_cmd.rsel      = scsf_pkg::RS_EL;
                n_state         = S_D1;
            end
            S_D1: begin
                o_cmd.line_mode = 1'b1;
                o_cmd.en_re     = 1'b1;
                o_cmd.rsel      = scsf_pkg::RS_EM;
                o_cmd.cap_en    = 1'b1;
                o_cmd.cap_idx   = 2'd0;
                n_state         = S_D2;
            end
            S_D2: begin
                o_cmd.line_mode = 1'b1;
                o_cmd.en_re     = 1'b1;
                o_cmd.rsel      = scsf_pkg::RS_ER;
                o_cmd.cap_en    = 1'b1;
                o_cmd.cap_idx   = 2'd1;
                n_state         = S_D3;
            end
            S_D3: begin
                o_cmd.line_mode = 1'b1;
                o_cmd.en_re     = 1'b1;
                o_cmd.rsel      = scsf_pkg::RS_EO;
                o_cmd.cap_en    = 1'b1;
                o_cmd.cap_idx   = 2'd2;
                n_state         = S_D4;
            end
            S_D4: begin
                o_cmd.line_mode = 1'b1;
                o_cmd.cap_en    = 1'b1;
                o_cmd.cap_idx   = 2'd3;
                n_state         = S_D5;
            end
            S_D5: begin
                o_cmd.line_mode = 1'b1;
                o_cmd.en_we     = 1'b1;
                o_cmd.en_wsel   = 1'b1;
                if (i_stat.last_a && i_stat.last_b) begin
                    o_cmd.ctr_op = scsf_pkg::CTR_MS;
                    n_state      = S_M0;
                end else begin
                    o_cmd.ctr_op = scsf_pkg::CTR_NEXT;
                    n_state      = S_D0;
                end
            end
            S_M0: begin
                o_cmd.line_mode = 1'b1;
                o_cmd.en_re     = 1'b1;
                o_cmd.rsel      = scsf_pkg::RS_EO;
                n_state         = S_M1;
            end
            S_M1: begin
                o_cmd.line_mode = 1'b1;
                o_cmd.best_upd  = 1'b1;
                if (i_stat.last_b) begin
                    n_state = S_M2;
                end else begin
                    o_cmd.ctr_op = scsf_pkg::CTR_NEXT;
                    n_state      = S_M0;
                end
            end
            S_M2: begin
                o_cmd.line_mode = 1'b1;
                o_cmd.seam_min  = 1'b1;
                n_state         = S_FIN;
            end
            S_B0: begin
                o_cmd.line_mode = 1'b1;
                o_cmd.ctr_op    = scsf_pkg::CTR_SEAM;
                n_state         = S_B1;
            end
            S_B1: begin
                o_cmd.line_mode = 1'b1;
                o_cmd.en_re     = 1'b1;
                o_cmd.rsel      = scsf_pkg::RS_EL;
                n_state         = S_B2;
            end
            S_B2: begin
                o_cmd.line_mode = 1'b1;
                o_cmd.en_re     = 1'b1;
                o_cmd.rsel      = scsf_pkg::RS_EM;
                o_cmd.cap_en    = 1'b1;
                o_cmd.cap_idx   = 2'd0;
                n_state         = S_B3;
            end
            S_B3: begin
                o_cmd.line_mode = 1'b1;
                o_cmd.en_re     = 1'b1;
                o_cmd.rsel      = scsf_pkg::RS_ER;
                o_cmd.cap_en    = 1'b1;
                o_cmd.cap_idx   = 2'd1;
                n_state         = S_B4;
            end
            S_B4: begin
                o_cmd.line_mode = 1'b1;
                o_cmd.cap_en    = 1'b1;
                o_cmd.cap_idx   = 2'd2;
                n_state         = S_B5;
            end
            S_B5: begin
                o_cmd.line_mode = 1'b1;
                o_cmd.bt_decide = 1'b1;
                n_state         = S_FIN;
            end
            S_FIN: begin
                if (!i_stat.out_block) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/scsf_dpath.sv]
module scsf_dpath #(
    parameter int MAX_WIDTH  = scsf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = scsf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  scsf_pkg::t_cmd                 i_cmd,
    output scsf_pkg::t_stat                o_stat,
    input  scsf_pkg::t_in_item             i_in_item,
    input  logic                           i_cfg_we,
    input  logic [scsf_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [scsf_pkg::CFG_DW-1:0]    i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output scsf_pkg::t_out_item            o_out_item
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int KW    = $clog2(MAXD);
    localparam int DW    = KW + 1;
    localparam int EW    = scsf_pkg::EN_W;
    localparam int PW    = scsf_pkg::PIX_W;

    // configuration
    logic                        r_dir;
    logic [scsf_pkg::CFG_DW-1:0] r_cfg_w, r_cfg_h;

    // control-side state
    logic          r_seam_valid;
    logic [KW-1:0] r_line, r_pos;
    logic [KW-1:0] r_a, r_b;
    logic          r_out_valid;

    // datapath registers
    logic [PW-1:0] r_d [4];
    logic [17:0]   r_acc;
    logic [EW-1:0] r_rem, r_root, r_bit;
    logic [scsf_pkg::SQ_CNT_W-1:0] r_sq_cnt;
    logic [EW-1:0] r_best_v;
    logic [KW-1:0] r_best_x;

    logic [DW-1:0] w_dim, h_dim, lines, poss, amax, bmax;
    logic          last_a, last_b;
    logic [KW-1:0] cl, cr, ru, rd, xl, xr, ym1;
    logic [AW-1:0] raddr, waddr_en, waddr_pix;
    logic          pix_we;
    logic [PW-1:0] pix_rdata;
    logic [EW-1:0] en_rdata, en_wdata;
    logic [EW-1:0] e0, e1, e2, e3, m, sat;
    logic [EW:0]   sum, sq_try;
    logic [EW-1:0] n_val;
    logic [KW-1:0] bt_x;
    logic [EW-1:0] k;

    function automatic logic [AW-1:0] lin(logic [KW-1:0] r, logic [KW-1:0] c);
        return AW'(r) * AW'(MAX_WIDTH) + AW'(c);
    endfunction

    function automatic logic [AW-1:0] at(logic d, logic [KW-1:0] l, logic [KW-1:0] p);
        return d ? lin(p, l) : lin(l, p);
    endfunction

    // dimension clamping
    always_comb begin
        if (r_cfg_w < scsf_pkg::CFG_DW'(2)) begin
            w_dim = DW'(2);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w_dim = DW'(MAX_WIDTH);
        end else begin
            w_dim = DW'(r_cfg_w);
        end
        if (r_cfg_h < scsf_pkg::CFG_DW'(2)) begin
            h_dim = DW'(2);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            h_dim = DW'(MAX_HEIGHT);
        end else begin
            h_dim = DW'(r_cfg_h);
        end
    end

    assign lines  = r_dir ? w_dim : h_dim;
    assign poss   = r_dir ? h_dim : w_dim;
    assign amax   = i_cmd.line_mode ? lines : h_dim;
    assign bmax   = i_cmd.line_mode ? poss : w_dim;
    assign last_a = ({1'b0, r_a} == amax - DW'(1));
    assign last_b = ({1'b0, r_b} == bmax - DW'(1));

    // wrap-around neighbors in the frame, clamped neighbors in a line
    assign cl  = (r_b == '0) ? KW'(w_dim - DW'(1)) : r_b - KW'(1);
    assign cr  = last_b ? '0 : r_b + KW'(1);
    assign ru  = (r_a == '0) ? KW'(h_dim - DW'(1)) : r_a - KW'(1);
    assign rd  = last_a ? '0 : r_a + KW'(1);
    assign xl  = (r_b == '0) ? r_b : r_b - KW'(1);
    assign xr  = last_b ? r_b : r_b + KW'(1);
    assign ym1 = r_a - KW'(1);

    always_comb begin
        case (i_cmd.rsel)
            scsf_pkg::RS_PL: raddr = lin(r_a, cl);
            scsf_pkg::RS_PR: raddr = lin(r_a, cr);
            scsf_pkg::RS_PU: raddr = lin(ru, r_b);
            scsf_pkg::RS_PD: raddr = lin(rd, r_b);
            scsf_pkg::RS_EL: raddr = at(r_dir, ym1, xl);
            scsf_pkg::RS_EM: raddr = at(r_dir, ym1, r_b);
            scsf_pkg::RS_ER: raddr = at(r_dir, ym1, xr);
            scsf_pkg::RS_EO: raddr = at(r_dir, r_a, r_b);
            default:         raddr = '0;
        endcase
    end

    // pixel writes outside the store are dropped
    assign pix_we = i_cmd.pix_we
                    && (32'(i_in_item.pixel_row) < 32'(MAX_HEIGHT))
                    && (32'(i_in_item.pixel_col) < 32'(MAX_WIDTH));
    assign waddr_pix = lin(KW'(i_in_item.pixel_row), KW'(i_in_item.pixel_col));

    scsf_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (waddr_pix),
        .i_wdata ({i_in_item.red, i_in_item.green, i_in_item.blue}),
        .i_re    (i_cmd.pix_re),
        .i_raddr (raddr),
        .o_rdata (pix_rdata)
    );

    // accumulation: current entry plus least of the previous line's three
    assign e0  = r_d[0][EW-1:0];
    assign e1  = r_d[1][EW-1:0];
    assign e2  = r_d[2][EW-1:0];
    assign e3  = r_d[3][EW-1:0];
    always_comb begin
        m = e1;
        if (e0 < m) m = e0;
        if (e2 < m) m = e2;
    end
    assign sum = {1'b0, e3} + {1'b0, m};
    assign sat = sum[EW] ? {EW{1'b1}} : sum[EW-1:0];

    assign waddr_en = i_cmd.en_wsel ? at(r_dir, r_a, r_b) : lin(r_a, r_b);
    assign en_wdata = i_cmd.en_wsel ? sat : r_root;

    scsf_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_en_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.en_we),
        .i_waddr (waddr_en),
        .i_wdata (en_wdata),
        .i_re    (i_cmd.en_re),
        .i_raddr (raddr),
        .o_rdata (en_rdata)
    );

    // square-root operand and trial subtraction
    assign n_val  = EW'(r_acc) + EW'(scsf_pkg::colour_dist(r_d[2], r_d[3]));
    assign sq_try = {1'b0, r_root} + {1'b0, r_bit};

    // backtrack step: e0 lower neighbor, e1 straight, e2 upper neighbor
    always_comb begin
        k    = (e1 < e2) ? e1 : e2;
        if (e0 < k) k = e0;
        bt_x = r_b;
        if (last_b) begin
            if (e0 <= e1) bt_x = r_b - KW'(1);
        end else if (r_b == '0) begin
            if (e2 <= e1) bt_x = KW'(1);
        end else begin
            if (k == e2) begin
                bt_x = r_b + KW'(1);
            end else if (k == e0) begin
                bt_x = r_b - KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            r_d[i_cmd.cap_idx] <= i_cmd.cap_pix ? pix_rdata : PW'(en_rdata);
        end
        if (i_cmd.dx) begin
            r_acc <= scsf_pkg::colour_dist(r_d[0], r_d[1]);
        end
        if (i_cmd.sq_start) begin
            r_rem  <= n_val;
            r_root <= '0;
            r_bit  <= EW'(1) << (2 * scsf_pkg::SQ_STEPS - 2);
        end else if (i_cmd.sq_step) begin
            if ({1'b0, r_rem} >= sq_try) begin
                r_rem  <= r_rem - sq_try[EW-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.best_upd && ((r_b == '0) || (en_rdata < r_best_v))) begin
            r_best_v <= en_rdata;
            r_best_x <= r_b;
        end
        if (i_cmd.out_load) begin
            o_out_item.seam_line     <= scsf_pkg::FIELD_W'(r_line);
            o_out_item.seam_position <= scsf_pkg::FIELD_W'(r_pos);
            o_out_item.last_entry    <= (r_line == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir        <= 1'b0;
            r_cfg_w      <= scsf_pkg::CFG_DW'(512);
            r_cfg_h      <= scsf_pkg::CFG_DW'(512);
            r_seam_valid <= 1'b0;
            r_line       <= '0;
            r_pos        <= '0;
            r_a          <= '0;
            r_b          <= '0;
            r_out_valid  <= 1'b0;
            r_sq_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    scsf_pkg::REG_DIRECTION: begin
                        r_dir        <= i_cfg_data[0];
                        r_seam_valid <= 1'b0;
                    end
                    scsf_pkg::REG_WIDTH: begin
                        r_cfg_w      <= i_cfg_data;
                        r_seam_valid <= 1'b0;
                    end
                    scsf_pkg::REG_HEIGHT: begin
                        r_cfg_h      <= i_cfg_data;
                        r_seam_valid <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.seam_clr) begin
                r_seam_valid <= 1'b0;
            end
            if (i_cmd.sq_start) begin
                r_sq_cnt <= scsf_pkg::SQ_CNT_W'(scsf_pkg::SQ_STEPS);
            end else if (i_cmd.sq_step) begin
                r_sq_cnt <= r_sq_cnt - scsf_pkg::SQ_CNT_W'(1);
            end
            case (i_cmd.ctr_op)
                scsf_pkg::CTR_ENERGY: begin
                    r_a <= '0;
                    r_b <= '0;
                end
                scsf_pkg::CTR_DP: begin
                    r_a <= KW'(1);
                    r_b <= '0;
                end
                scsf_pkg::CTR_MS: begin
                    r_a <= KW'(lines - DW'(1));
                    r_b <= '0;
                end
                scsf_pkg::CTR_SEAM: begin
                    r_a <= r_line;
                    r_b <= r_pos;
                end
                scsf_pkg::CTR_NEXT: begin
                    if (last_b) begin
                        r_b <= '0;
                        r_a <= r_a + KW'(1);
                    end else begin
                        r_b <= r_b + KW'(1);
                    end
                end
                default: begin
                end
            endcase
            if (i_cmd.seam_min) begin
                r_line       <= KW'(lines - DW'(1));
                r_pos        <= r_best_x;
                r_seam_valid <= 1'b1;
            end
            if (i_cmd.bt_decide) begin
                r_line <= ym1;
                r_pos  <= bt_x;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                if (r_line == '0) begin
                    r_seam_valid <= 1'b0;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_stat.sq_busy    = (r_sq_cnt != '0);
    assign o_stat.last_a     = last_a;
    assign o_stat.last_b     = last_b;
    assign o_stat.seam_valid = r_seam_valid;
    assign o_stat.out_block  = r_out_valid && i_out_stall;

endmodule

[rtl/core/seam_carving_seam_finder_core.sv]
// Pixel write: one item per cycle while no fetch is in progress; no result.
// Later fetch of a seam in progress: three energy-RAM reads, then a backtrack step.
// First fetch of a seam: energy for each pixel (four pixel reads and a 10-step
// square root), accumulation for each entry, and a minimum search over the
// last line; the input is stalled throughout.
// Synchronous active-low reset restores register defaults and drops any seam.
module seam_carving_seam_finder_core #(
    parameter int MAX_WIDTH  = scsf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = scsf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  scsf_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output scsf_pkg::t_out_item         o_out_item,
    input  logic                        i_cfg_we,
    input  logic [scsf_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [scsf_pkg::CFG_DW-1:0] i_cfg_data
);

    scsf_pkg::t_cmd  cmd;
    scsf_pkg::t_stat stat;

    scsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_fetch (i_in_item.command),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    scsf_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[tb/seam_carving_seam_finder_core_tb.sv]
`timescale 1ns / 1ps

module seam_carving_seam_finder_core_tb;

    localparam int FRAME_W = 512;
    localparam int FRAME_H = 512;
    localparam int ENERGY_SAT = 524287;
    localparam int STALL_LIMIT = 400000;
    localparam logic [scsf_pkg::CFG_IW-1:0] REG_UNUSED = 2'd3;

    logic                          clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    scsf_pkg::t_in_item            i_in_item;
    logic                          o_out_valid;
    logic                          i_out_stall;
    scsf_pkg::t_out_item           o_out_item;
    logic                          i_cfg_we;
    logic [scsf_pkg::CFG_IW-1:0]   i_cfg_index;
    logic [scsf_pkg::CFG_DW-1:0]   i_cfg_data;

    seam_carving_seam_finder_core dut (
        .i_clk      (clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // predictor state
    logic [23:0]  frame_pix [FRAME_W*FRAME_H];
    int unsigned  cum_energy [FRAME_W*FRAME_H];
    bit           seam_live;
    int unsigned  seam_pos;
    int unsigned  seam_ln;
    bit           horiz;
    logic [9:0]   width_reg;
    logic [9:0]   height_reg;

    scsf_pkg::t_in_item  pending_items[$];
    scsf_pkg::t_out_item expected_entries[$];
    int           errors;
    int           stall_cycles;
    int           random_items;
    bit           no_idle;

    function automatic int unsigned sat_dim(logic [9:0] v, int unsigned maxv);
        if (v < 2) return 2;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int unsigned floor_sqrt(int unsigned n);
        int unsigned r;
        r = 0;
        for (int b = 10; b >= 0; b--) begin
            if ((r | (1 << b)) * (r | (1 << b)) <= n) r = r | (1 << b);
        end
        return r;
    endfunction

    function automatic int unsigned rgb_diff(logic [23:0] a, logic [23:0] b);
        int unsigned s;
        int d;
        s = 0;
        for (int k = 0; k < 3; k++) begin
            d = int'(a[k*8 +: 8]) - int'(b[k*8 +: 8]);
            s += d * d;
        end
        return s;
    endfunction

    function automatic int unsigned en_idx(int unsigned ln, int unsigned p);
        return horiz ? p * FRAME_W + ln : ln * FRAME_W + p;
    endfunction

    function automatic void build_energy(int unsigned w, int unsigned h);
        int unsigned cl, cr, ru, rd, m, s, nl, np;
        for (int unsigned r = 0; r < h; r++) begin
            for (int unsigned c = 0; c < w; c++) begin
                cl = (c == 0) ? w - 1 : c - 1;
                cr = (c == w - 1) ? 0 : c + 1;
                ru = (r == 0) ? h - 1 : r - 1;
                rd = (r == h - 1) ? 0 : r + 1;
                cum_energy[r*FRAME_W + c] = floor_sqrt(
                    rgb_diff(frame_pix[r*FRAME_W + cl], frame_pix[r*FRAME_W + cr]) +
                    rgb_diff(frame_pix[ru*FRAME_W + c], frame_pix[rd*FRAME_W + c]));
            end
        end
        nl = horiz ? w : h;
        np = horiz ? h : w;
        for (int unsigned y = 1; y < nl; y++) begin
            for (int unsigned x = 0; x < np; x++) begin
                m = cum_energy[en_idx(y-1, x)];
                if (x > 0 && cum_energy[en_idx(y-1, x-1)] < m) m = cum_energy[en_idx(y-1, x-1)];
                if (x + 1 < np && cum_energy[en_idx(y-1, x+1)] < m)
                    m = cum_energy[en_idx(y-1, x+1)];
                s = cum_energy[en_idx(y, x)] + m;
                cum_energy[en_idx(y, x)] = (s > ENERGY_SAT) ? ENERGY_SAT : s;
            end
        end
    endfunction

    function automatic void predict_item(scsf_pkg::t_in_item it);
        int unsigned w, h, np, nl, x, y, up, dn, st, k;
        scsf_pkg::t_out_item e;
        w = sat_dim(width_reg, FRAME_W);
        h = sat_dim(height_reg, FRAME_H);
        np = horiz ? h : w;
        nl = horiz ? w : h;
        if (it.command == scsf_pkg::CMD_WRITE) begin
            frame_pix[it.pixel_row*FRAME_W + it.pixel_col] = {it.red, it.green, it.blue};
            seam_live = 0;
            return;
        end
        if (!seam_live) begin
            build_energy(w, h);
            x = 0;
            for (int unsigned p = 1; p < np; p++)
                if (cum_energy[en_idx(nl-1, p)] < cum_energy[en_idx(nl-1, x)]) x = p;
            seam_ln = nl - 1;
            seam_pos = x;
            seam_live = 1;
        end else begin
            y = seam_ln;
            x = seam_pos;
            if (x == np - 1) begin
                if (cum_energy[en_idx(y-1, x-1)] <= cum_energy[en_idx(y-1, x)]) x = x - 1;
            end else if (x == 0) begin
                if (cum_energy[en_idx(y-1, 1)] <= cum_energy[en_idx(y-1, 0)]) x = 1;
            end else begin
                up = cum_energy[en_idx(y-1, x+1)];
                dn = cum_energy[en_idx(y-1, x-1)];
                st = cum_energy[en_idx(y-1, x)];
                k = (st < up) ? st : up;
                if (dn < k) k = dn;
                if (k == up) x = x + 1;
                else if (k == dn) x = x - 1;
            end
            seam_ln = y - 1;
            seam_pos = x;
        end
        e.seam_line = seam_ln[8:0];
        e.seam_position = seam_pos[8:0];
        e.last_entry = (seam_ln == 0);
        if (seam_ln == 0) seam_live = 0;
        expected_entries.push_back(e);
    endfunction

    // sampling, checking and watchdog
    bit in_taken;
    always @(posedge clk) begin
        scsf_pkg::t_out_item e;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_entries.size() == 0) begin
                $error("unexpected seam entry %p", o_out_item);
                errors++;
            end else begin
                e = expected_entries.pop_front();
                if (o_out_item.seam_line !== e.seam_line) begin
                    $error("seam_line exp %0d got %0d", e.seam_line, o_out_item.seam_line);
                    errors++;
                end
                if (o_out_item.seam_position !== e.seam_position) begin
                    $error("seam_position exp %0d got %0d", e.seam_position,
                           o_out_item.seam_position);
                    errors++;
                end
                if (o_out_item.last_entry !== e.last_entry) begin
                    $error("last_entry exp %0d got %0d", e.last_entry, o_out_item.last_entry);
                    errors++;
                end
            end
        end
        if (in_taken) predict_item(i_in_item);
        if (in_taken || (o_out_valid && !i_out_stall)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles > STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // item driver
    always @(negedge clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 27)) begin
                i_in_item <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        i_out_stall <= !no_idle && ($urandom_range(99) < 27);
    end

    task automatic reg_write(logic [scsf_pkg::CFG_IW-1:0] idx,
                             logic [scsf_pkg::CFG_DW-1:0] val);
        @(negedge clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge clk);
        i_cfg_we <= 1'b0;
        case (idx)
            scsf_pkg::REG_DIRECTION: begin horiz = val[0]; seam_live = 0; end
            scsf_pkg::REG_WIDTH:     begin width_reg = val; seam_live = 0; end
            scsf_pkg::REG_HEIGHT:    begin height_reg = val; seam_live = 0; end
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !i_in_valid && expected_entries.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    function automatic void add_write(int r, int c, logic [7:0] rr, logic [7:0] g,
                                      logic [7:0] b);
        scsf_pkg::t_in_item it;
        it.command = scsf_pkg::CMD_WRITE;
        it.pixel_row = 9'(r);
        it.pixel_col = 9'(c);
        it.red = rr;
        it.green = g;
        it.blue = b;
        pending_items.push_back(it);
    endfunction

    function automatic void add_fetches(int n);
        scsf_pkg::t_in_item it;
        it = '0;
        it.command = scsf_pkg::CMD_FETCH;
        it.pixel_row = 9'($urandom);
        it.pixel_col = 9'($urandom);
        it.red = 8'($urandom);
        for (int i = 0; i < n; i++) pending_items.push_back(it);
    endfunction

    // configure, fill the whole frame, then mixed traffic
    task automatic run_setting(bit d, logic [9:0] wv, logic [9:0] hv, int nops);
        int unsigned w, h, nl;
        reg_write(scsf_pkg::REG_DIRECTION, {9'd0, d});
        reg_write(scsf_pkg::REG_WIDTH, wv);
        reg_write(scsf_pkg::REG_HEIGHT, hv);
        w = sat_dim(wv, FRAME_W);
        h = sat_dim(hv, FRAME_H);
        nl = d ? w : h;
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                add_write(r, c, 8'($urandom), 8'($urandom), 8'($urandom));
        add_fetches(nl);
        for (int i = 0; i < nops; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: add_fetches(nl);
                6: begin
                    add_fetches($urandom_range(1, nl));
                    add_write($urandom_range(h-1), $urandom_range(w-1),
                              8'($urandom), 8'($urandom), 8'($urandom));
                end
                7: add_write($urandom_range(511), $urandom_range(511),
                             8'($urandom), 8'($urandom), 8'($urandom));
                default: add_write($urandom_range(h-1), $urandom_range(w-1),
                                   ($urandom_range(1) ? 8'hff : 8'h00),
                                   8'($urandom), 8'($urandom));
            endcase
        end
        random_items += pending_items.size();
        drain();
    endtask

    initial begin
        logic [9:0] wv, hv;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = scsf_pkg::REG_DIRECTION;
        i_cfg_data = '0;
        errors = 0;
        stall_cycles = 0;
        random_items = 0;
        no_idle = 0;
        horiz = 0;
        width_reg = 10'd512;
        height_reg = 10'd512;
        seam_live = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        i_rst_n = 1'b1;

        // directed: smallest frame via saturation, color extremes, ties
        reg_write(scsf_pkg::REG_WIDTH, 10'd0);
        reg_write(scsf_pkg::REG_HEIGHT, 10'd1);
        add_write(0, 0, 8'hff, 8'hff, 8'hff);
        add_write(0, 1, 8'h00, 8'h00, 8'h00);
        add_write(1, 0, 8'h00, 8'hff, 8'h00);
        add_write(1, 1, 8'hff, 8'h00, 8'hff);
        add_write(511, 511, 8'haa, 8'h55, 8'h0f);
        add_write(256, 1, 8'h01, 8'h02, 8'h04);
        add_fetches(2);
        add_fetches(1);
        add_write(0, 0, 8'h00, 8'h00, 8'h00);
        add_fetches(2);
        drain();
        reg_write(scsf_pkg::REG_DIRECTION, 10'd1);
        add_fetches(1);
        drain();
        reg_write(REG_UNUSED, 10'h3ff);
        add_fetches(1);
        drain();
        // uniform frame: every neighbor ties
        reg_write(scsf_pkg::REG_DIRECTION, 10'd0);
        reg_write(scsf_pkg::REG_WIDTH, 10'd4);
        reg_write(scsf_pkg::REG_HEIGHT, 10'd4);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) add_write(r, c, 8'h80, 8'h80, 8'h80);
        add_fetches(4);
        drain();

        // widest frame through saturation of an oversized width
        run_setting(1'b0, 10'h3ff, 10'd2, 2);
        run_setting(1'b1, 10'h3ff, 10'd1, 1);
        random_items = 0;

        while (random_items < 1050) begin
            no_idle = ($urandom_range(7) == 0);
            wv = ($urandom_range(9) == 0) ? 10'($urandom_range(1)) : 10'($urandom_range(2, 9));
            hv = ($urandom_range(9) == 0) ? 10'($urandom_range(1)) : 10'($urandom_range(2, 9));
            run_setting(1'($urandom_range(1)), wv, hv, $urandom_range(4, 10));
            if ($urandom_range(5) == 0) reg_write(REG_UNUSED, 10'($urandom));
        end
        no_idle = 0;

        drain();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
